FILE: hw/rtl/ncu_pkg.sv
// Shared types, constants and helpers for the network coordinate update block.
package ncu_pkg;

    localparam int AXES_DEF = 3;
    localparam int AXES_MAX = 3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [23:0] MAX24   = 24'hFFFFFF;
    localparam logic [30:0] MAX31   = 31'h7FFFFFFF;

    // Start point of the local coordinate: +0.1, -0.1, +0.05 in Q8.24.
    localparam logic signed [31:0] START_POINT [AXES_MAX] = '{
        32'sd1677722, -32'sd1677722, 32'sd838861
    };

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_USE_SCALED  = 3'd0;
    localparam logic [2:0] REG_ERROR_GAIN  = 3'd1;
    localparam logic [2:0] REG_COORD_GAIN  = 3'd2;
    localparam logic [2:0] REG_LOSS_GAIN   = 3'd3;
    localparam logic [2:0] REG_LOSS_LIMIT  = 3'd4;
    localparam logic [2:0] REG_ENABLE_HGT  = 3'd5;
    localparam logic [2:0] REG_ACTIVE_AXES = 3'd6;

    // Control from the sequencer to each lane.
    typedef struct packed {
        logic capture;   // latch the axis difference
        logic shift;     // halve magnitudes before squaring
        logic sq_en;     // register the square
        logic prod_en;   // register force times magnitude
        logic div_start; // start the step division
        logic commit;    // write the new coordinate
        logic neg;       // prediction miss is negative
    } lane_ctrl_t;

    // Clamp a Q1.16 gain to 1.0.
    function automatic logic [16:0] gain_clip(input logic [16:0] g);
        gain_clip = (g > ONE_Q16) ? ONE_Q16 : g;
    endfunction

endpackage

FILE: hw/rtl/network_coordinate_update.sv
// Top level of the network coordinate update block: sequencer, error and loss state.
//
// Usage: requests enter on in_valid/in_ready; func = 0 is an update from a
// measured round trip, func = 1 a query of the predicted distance. Each
// request yields one result on out_valid/out_ready, carrying the distance,
// accuracy and the local state after the request. Registers are written on
// cfg_we with cfg_index/cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this. A query, or an
// update whose round trip is zero or less, is done once the 32-step square
// root has run. An update under the scaled rule adds the weight division and
// the per-axis step division; the plain rule also runs the relative error
// division. A zero predicted distance skips the step division. The axes
// work in parallel lanes, each with its own multiplier and divider; one
// request is in flight at a time, and the next one is accepted in the
// cycle after the result is loaded.
// Reset: the coordinate returns to its start point, height and loss factor
// clear, the local error is 1.0 and all registers take their defaults.
// Stall: a finished result waits in the output register; the block holds the
// next result at its last step until the receiver takes the current one.
module network_coordinate_update #(
    parameter int AXES = ncu_pkg::AXES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [31:0] rtt,
    input  logic signed [31:0] remote_coord_0,
    input  logic signed [31:0] remote_coord_1,
    input  logic signed [31:0] remote_coord_2,
    input  logic [30:0]        remote_height,
    input  logic [23:0]        remote_error,
    input  logic [23:0]        avg_abs_prediction_error,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               applied,
    output logic [30:0]        distance,
    output logic [23:0]        accuracy,
    output logic signed [31:0] local_coord_0,
    output logic signed [31:0] local_coord_1,
    output logic signed [31:0] local_coord_2,
    output logic [30:0]        local_height,
    output logic [23:0]        local_error
);
    import ncu_pkg::*;

    localparam logic [1:0] AXES_W = AXES[1:0];

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ      = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_ROOT    = 4'd3;
    localparam logic [3:0] S_RWAIT   = 4'd4;
    localparam logic [3:0] S_EVAL    = 4'd5;
    localparam logic [3:0] S_WWAIT   = 4'd6;
    localparam logic [3:0] S_RELST   = 4'd7;
    localparam logic [3:0] S_RELWAIT = 4'd8;
    localparam logic [3:0] S_E1      = 4'd9;
    localparam logic [3:0] S_E2      = 4'd10;
    localparam logic [3:0] S_E3      = 4'd11;
    localparam logic [3:0] S_E4      = 4'd12;
    localparam logic [3:0] S_QST     = 4'd13;
    localparam logic [3:0] S_QWAIT   = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    // Configuration.
    logic        use_scaled_reg;
    logic [16:0] error_gain_reg;
    logic [16:0] coord_gain_reg;
    logic [16:0] loss_gain_reg;
    logic [30:0] loss_limit_reg;
    logic        enable_height_reg;
    logic [1:0]  active_axes_reg;

    // Block state.
    logic [30:0] height_reg;
    logic [23:0] error_reg;
    logic [16:0] loss_reg;

    // Request and working registers.
    logic [3:0]         state_reg;
    logic               func_reg;
    logic signed [31:0] rtt_reg;
    logic [30:0]        rh_reg;
    logic [23:0]        rerr_reg;
    logic [23:0]        avg_reg;
    logic               sh_reg;
    logic [63:0]        sum_reg;
    logic [33:0]        dist_reg;
    logic [34:0]        miss_reg;
    logic               neg_reg;
    logic [16:0]        w_reg;
    logic [23:0]        rel_reg;
    logic [16:0]        ew_reg;
    logic [16:0]        cw_reg;
    logic [16:0]        loss_new_reg;
    logic [40:0]        p1_reg;
    logic [40:0]        p2_reg;
    logic [16:0]        delta_reg;
    logic [31:0]        force_reg;
    logic               applied_reg;
    logic [23:0]        acc_reg;

    // Output registers.
    logic               out_valid_reg;
    logic               out_applied_reg;
    logic [30:0]        out_dist_reg;
    logic [23:0]        out_acc_reg;
    logic signed [31:0] out_coord_reg [AXES_MAX];
    logic [30:0]        out_height_reg;
    logic [23:0]        out_error_reg;

    logic               in_fire;
    logic [1:0]         n_axes;
    logic [AXES-1:0]    lane_active;
    logic [AXES-1:0]    lane_hi;
    logic [AXES-1:0]    lane_busy;
    logic               step_busy;
    logic signed [31:0] lane_coord [AXES];
    logic [63:0]        lane_sq [AXES];
    logic signed [31:0] rc [AXES_MAX];
    lane_ctrl_t         ctrl [AXES];
    logic               any_hi;
    logic [63:0]        sum_next;

    logic        root_start;
    logic        root_busy;
    logic [31:0] root;
    logic        div_start;
    logic [50:0] div_num;
    logic [30:0] div_den;
    logic        div_busy;
    logic [50:0] div_q;

    logic [16:0] eg;
    logic [16:0] cg;
    logic [16:0] lg;
    logic [24:0] err_sum;
    logic [32:0] root_base;
    logic [33:0] dist_next;
    logic signed [35:0] miss_e;
    logic [34:0] miss_mag;
    logic [16:0] g_sel;
    logic [23:0] x_sel;
    logic [33:0] prod_ew;
    logic [33:0] prod_cw;
    logic [33:0] prod_loss;
    logic [16:0] loss_next;
    logic [33:0] prod_delta;
    logic [41:0] err_acc;
    logic [51:0] prod_force;
    logic signed [33:0] hv;
    logic [30:0] height_next;
    logic [24:0] half_sum;
    logic        out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign eg = gain_clip(error_gain_reg);
    assign cg = gain_clip(coord_gain_reg);
    assign lg = gain_clip(loss_gain_reg);

    // Clamp the axis count to 1..AXES.
    always_comb
    begin
        if (active_axes_reg == 2'd0)
            n_axes = 2'd1;
        else if (active_axes_reg > AXES_W)
            n_axes = AXES_W;
        else
            n_axes = active_axes_reg;
    end

    assign rc[0] = remote_coord_0;
    assign rc[1] = remote_coord_1;
    assign rc[2] = remote_coord_2;

    // All step dividers start together and finish together.
    assign step_busy = |lane_busy;

    // Lanes: one per axis, all driven by the same sequencer step.
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        assign lane_active[i]    = 2'(i) < n_axes;
        assign ctrl[i].capture   = in_fire;
        assign ctrl[i].shift     = any_hi;
        assign ctrl[i].sq_en     = (state_reg == S_SQ);
        assign ctrl[i].prod_en   = (state_reg == S_E4);
        assign ctrl[i].div_start = (state_reg == S_QST);
        assign ctrl[i].commit    = (state_reg == S_QWAIT) && !step_busy && lane_active[i];
        assign ctrl[i].neg       = neg_reg;

        ncu_lane #(.START(START_POINT[i])) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl[i]),
            .remote_coord  (rc[i]),
            .force_mag     (force_reg),
            .pred_distance (dist_reg),
            .coord         (lane_coord[i]),
            .mag_hi        (lane_hi[i]),
            .sq            (lane_sq[i]),
            .busy          (lane_busy[i])
        );
    end

    // Merge: widest-magnitude test and sum of squares over the active lanes.
    assign any_hi = |(lane_hi & lane_active);

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < AXES; i++)
            if (lane_active[i])
                sum_next = sum_next + lane_sq[i];
    end

    assign root_start = (state_reg == S_ROOT);

    ncu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .x     (sum_reg),
        .busy  (root_busy),
        .root  (root)
    );

    // Shared scalar divider: weight first, then, under the plain rule, the relative error sample.
    assign err_sum   = {1'b0, error_reg} + {1'b0, rerr_reg};
    assign div_start = (state_reg == S_EVAL) || (state_reg == S_RELST);
    assign div_num   = (state_reg == S_EVAL) ? {11'd0, error_reg, 16'd0} : {miss_reg, 16'd0};
    assign div_den   = (state_reg == S_EVAL) ? {6'd0, err_sum} : rtt_reg[30:0];

    ncu_div #(.NW(51), .DW(31)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // Datapath terms for each step.
    always_comb
    begin
        root_base  = sh_reg ? {root, 1'b0} : {1'b0, root};
        dist_next  = {1'b0, root_base};
        if (enable_height_reg)
            dist_next = dist_next + 34'(height_reg) + 34'(rh_reg);
        miss_e     = 36'(rtt_reg) - $signed({2'b00, dist_reg});
        miss_mag   = miss_e[35] ? 35'(-miss_e) : miss_e[34:0];
        half_sum   = ({1'b0, rerr_reg} + {1'b0, error_reg}) >> 1;
        prod_ew    = 34'(eg) * 34'(w_reg);
        prod_cw    = 34'(cg) * 34'(w_reg);
        prod_loss  = 34'(ONE_Q16 - lg) * 34'(loss_reg);
        loss_next  = (miss_reg > 35'(loss_limit_reg)) ? 17'd0 : 17'(lg + prod_loss[32:16]);
        g_sel      = use_scaled_reg ? eg : ew_reg;
        x_sel      = use_scaled_reg ? avg_reg : rel_reg;
        prod_delta = 34'(cw_reg) * 34'(ONE_Q16 - loss_new_reg);
        err_acc    = 42'(p1_reg) + 42'(p2_reg);
        prod_force = 52'(miss_reg) * 52'(delta_reg);
        hv         = neg_reg ? 34'(height_reg) - $signed({2'b00, force_reg})
                             : 34'(height_reg) + $signed({2'b00, force_reg});
        if (hv < 0)
            height_next = '0;
        else if (hv > 34'sh0_7FFF_FFFF)
            height_next = MAX31;
        else
            height_next = hv[30:0];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_scaled_reg    <= 1'b0;
            error_gain_reg    <= 17'd16384;
            coord_gain_reg    <= 17'd16384;
            loss_gain_reg     <= 17'd0;
            loss_limit_reg    <= 31'd16777216;
            enable_height_reg <= 1'b0;
            active_axes_reg   <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_USE_SCALED:  use_scaled_reg    <= cfg_data[0];
                REG_ERROR_GAIN:  error_gain_reg    <= cfg_data[16:0];
                REG_COORD_GAIN:  coord_gain_reg    <= cfg_data[16:0];
                REG_LOSS_GAIN:   loss_gain_reg     <= cfg_data[16:0];
                REG_LOSS_LIMIT:  loss_limit_reg    <= cfg_data;
                REG_ENABLE_HGT:  enable_height_reg <= cfg_data[0];
                REG_ACTIVE_AXES: active_axes_reg   <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            height_reg    <= '0;
            error_reg     <= 24'(ONE_Q16);
            loss_reg      <= '0;
        end
        else
        begin
            // Drop valid once taken, unless a new result loads at this edge.
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                        state_reg <= S_SQ;
                S_SQ:
                    state_reg <= S_SUM;
                S_SUM:
                    state_reg <= S_ROOT;
                S_ROOT:
                    state_reg <= S_RWAIT;
                S_RWAIT:
                    if (!root_busy)
                        state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (func_reg || rtt_reg <= 0)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_WWAIT;
                end
                S_WWAIT:
                    if (!div_busy)
                        state_reg <= use_scaled_reg ? S_E1 : S_RELST;
                S_RELST:
                    state_reg <= S_RELWAIT;
                S_RELWAIT:
                    if (!div_busy)
                        state_reg <= S_E1;
                S_E1:
                    state_reg <= S_E2;
                S_E2:
                    state_reg <= S_E3;
                S_E3:
                begin
                    error_reg <= err_acc[39:16];
                    if (use_scaled_reg)
                        loss_reg <= loss_new_reg;
                    state_reg <= (dist_reg == '0) ? S_DONE : S_E4;
                end
                S_E4:
                    state_reg <= S_QST;
                S_QST:
                    state_reg <= S_QWAIT;
                S_QWAIT:
                    if (!step_busy)
                    begin
                        if (enable_height_reg)
                            height_reg <= height_next;
                        state_reg <= S_DONE;
                    end
                S_DONE:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers of the working path.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            rtt_reg  <= rtt;
            rh_reg   <= remote_height;
            rerr_reg <= remote_error;
            avg_reg  <= avg_abs_prediction_error;
        end
        if (state_reg == S_SQ)
            sh_reg <= any_hi;
        if (state_reg == S_SUM)
            sum_reg <= sum_next;
        if (state_reg == S_RWAIT && !root_busy)
            dist_reg <= dist_next;
        if (state_reg == S_EVAL)
        begin
            miss_reg    <= miss_mag;
            neg_reg     <= miss_e[35];
            applied_reg <= !func_reg && rtt_reg > 0;
            if (func_reg && enable_height_reg)
                acc_reg <= rerr_reg;
            else if (func_reg && rerr_reg < 24'(ONE_Q16) && error_reg < 24'(ONE_Q16))
                acc_reg <= 24'(ONE_Q16) - half_sum[23:0];
            else
                acc_reg <= '0;
            if (!func_reg && rtt_reg <= 0)
                dist_reg <= '0;
        end
        if (state_reg == S_WWAIT && !div_busy)
            w_reg <= (err_sum == '0) ? 17'd0 : div_q[16:0];
        if (state_reg == S_RELWAIT && !div_busy)
            rel_reg <= (div_q > 51'(MAX24)) ? MAX24 : div_q[23:0];
        if (state_reg == S_E1)
        begin
            ew_reg       <= prod_ew[32:16];
            cw_reg       <= prod_cw[32:16];
            loss_new_reg <= loss_next;
        end
        if (state_reg == S_E2)
        begin
            p1_reg    <= 41'(x_sel) * 41'(g_sel);
            p2_reg    <= 41'(error_reg) * 41'(ONE_Q16 - g_sel);
            delta_reg <= use_scaled_reg ? prod_delta[32:16] : cw_reg;
        end
        if (state_reg == S_E3)
            force_reg <= (prod_force[51:16] > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : prod_force[47:16];
        if (state_reg == S_DONE && out_free)
        begin
            out_applied_reg <= applied_reg;
            out_dist_reg    <= (dist_reg > 34'(MAX31)) ? MAX31 : dist_reg[30:0];
            out_acc_reg     <= acc_reg;
            out_height_reg  <= height_reg;
            out_error_reg   <= error_reg;
            for (int i = 0; i < AXES_MAX; i++)
                out_coord_reg[i] <= (i < AXES) ? lane_coord[(i < AXES) ? i : 0] : 32'sd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign applied       = out_applied_reg;
    assign distance      = out_dist_reg;
    assign accuracy      = out_acc_reg;
    assign local_coord_0 = out_coord_reg[0];
    assign local_coord_1 = out_coord_reg[1];
    assign local_coord_2 = out_coord_reg[2];
    assign local_height  = out_height_reg;
    assign local_error   = out_error_reg;
endmodule

FILE: hw/rtl/ncu_div.sv
// Restoring divider, one quotient bit per cycle.
module ncu_div #(
    parameter int NW = 64,
    parameter int DW = 34
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg, num_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            rem_reg  <= fits ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            quot_reg <= {quot_reg[NW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
endmodule

FILE: hw/rtl/ncu_sqrt.sv
// Integer square root of a 64-bit value, one root bit per cycle.
module ncu_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        busy,
    output logic [31:0] root
);
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic        fits;

    assign shifted = {rem_reg, x_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= fits ? 34'(shifted - trial) : shifted[33:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

FILE: hw/rtl/ncu_lane.sv
// One coordinate axis: difference, square, step division and saturating update.
module ncu_lane #(
    parameter logic signed [31:0] START = 32'sd0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ncu_pkg::lane_ctrl_t       ctrl,
    input  logic signed [31:0]        remote_coord,
    input  logic [31:0]               force_mag,
    input  logic [33:0]               pred_distance,
    output logic signed [31:0]        coord,
    output logic                      mag_hi,
    output logic [63:0]               sq,
    output logic                      busy
);
    import ncu_pkg::*;

    logic signed [31:0] coord_reg;
    logic signed [32:0] d_reg;
    logic [32:0]        mag;
    logic [31:0]        a;
    logic [63:0]        sq_reg;
    logic [63:0]        prod_reg;
    logic [64:0]        prod_full;
    logic [63:0]        q;
    logic [33:0]        q_sat;
    logic signed [35:0] nv;
    logic signed [31:0] coord_next;

    assign mag       = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
    assign a         = ctrl.shift ? mag[32:1] : mag[31:0];
    assign prod_full = 65'(force_mag) * 65'(mag);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            d_reg <= 33'(coord_reg) - 33'(remote_coord);
        if (ctrl.sq_en)
            sq_reg <= 64'(a) * 64'(a);
        if (ctrl.prod_en)
            prod_reg <= prod_full[63:0];
    end

    ncu_div #(.NW(64), .DW(34)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (prod_reg),
        .den   (pred_distance),
        .busy  (busy),
        .quot  (q)
    );

    // Cap the step at 2^33, then move toward or away from the peer.
    always_comb
    begin
        q_sat = (q > 64'h2_0000_0000) ? 34'h2_0000_0000 : q[33:0];
        if (ctrl.neg != d_reg[32])
            nv = 36'(coord_reg) - $signed({2'b00, q_sat});
        else
            nv = 36'(coord_reg) + $signed({2'b00, q_sat});
        if (nv > 36'sh0_7FFF_FFFF)
            coord_next = 32'sh7FFF_FFFF;
        else if (nv < -36'sh0_8000_0000)
            coord_next = 32'sh8000_0000;
        else
            coord_next = nv[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coord_reg <= START;
        else if (ctrl.commit)
            coord_reg <= coord_next;
    end

    assign coord  = coord_reg;
    assign mag_hi = mag[32] | mag[31];
    assign sq     = sq_reg;
endmodule
